// File: design/text_console_writer_top_assert.svh
// Assertion macros for the text console writer checker.
// Included by the checker file; depends on nothing else.
`ifndef TEXT_CONSOLE_WRITER_TOP_ASSERT_SVH
`define TEXT_CONSOLE_WRITER_TOP_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define TCW_ASSERT_NOW(name, clk, rst_n, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled during reset.
`define TCW_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

// Next-cycle implication that also holds across reset.
`define TCW_ASSERT_NEXT_ALWAYS(name, clk, ante, cons, msg) \
	name: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

// File: design/tcw_pkg.sv
// Shared widths, codes and request types for the text console writer.
// No dependencies.
package tcw_pkg;

	localparam int ACTION_W = 3;
	localparam int CHAR_W   = 8;
	localparam int POS_W    = 11;
	localparam int CURSOR_W = 11;
	localparam int COLOR_W  = 8;
	localparam int CELL_W   = CHAR_W + COLOR_W;

	localparam logic [ACTION_W-1:0] ACT_PUT    = 3'd0;
	localparam logic [ACTION_W-1:0] ACT_BACK   = 3'd1;
	localparam logic [ACTION_W-1:0] ACT_CLEAR  = 3'd2;
	localparam logic [ACTION_W-1:0] ACT_SETCUR = 3'd3;
	localparam logic [ACTION_W-1:0] ACT_READ   = 3'd4;

	localparam logic [CHAR_W-1:0]  CH_NEWLINE = 8'd10;
	localparam logic [CHAR_W-1:0]  CH_SPACE   = 8'd32;
	localparam logic [COLOR_W-1:0] RESET_ATTR = 8'd7;

	typedef enum logic [2:0] {
		OP_PUT,
		OP_NEWLINE,
		OP_BACK,
		OP_CLEAR,
		OP_SETCUR,
		OP_READ,
		OP_NOP
	} op_kind_t;

	typedef struct packed {
		op_kind_t            kind;
		logic [CHAR_W-1:0]   ch;
		logic                in_range;
	} op_t;

endpackage

// File: design/tcw_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module tcw_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 2000,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

// File: design/tcw_front.sv
// Front end: takes input requests, classifies them and clamps the position.
// Depends on tcw_pkg.
module tcw_front import tcw_pkg::*; #(
	parameter int ROW_COUNT = 25,
	parameter int COL_COUNT = 80,
	localparam int CELL_COUNT = ROW_COUNT * COL_COUNT,
	localparam int CUR_W = $clog2(CELL_COUNT)
) (
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [ACTION_W-1:0] action,
	input  logic [CHAR_W-1:0]   char_code,
	input  logic [POS_W-1:0]    position,
	input  logic                q_full,
	input  logic                init_busy,
	output logic                push,
	output op_t                 push_op,
	output logic [CUR_W-1:0]    push_addr
);

	localparam int CMP_W = ((CUR_W > POS_W) ? CUR_W : POS_W) + 1;

	logic [CMP_W-1:0] pos_ext;
	logic             in_range;

	assign pos_ext  = CMP_W'(position);
	assign in_range = pos_ext < CMP_W'(CELL_COUNT);

	assign in_stall = q_full || init_busy;
	assign push     = in_valid && !in_stall;

	always_comb begin
		push_op.ch       = char_code;
		push_op.in_range = in_range;
		unique case (action)
			ACT_PUT: begin
				push_op.kind = (char_code == CH_NEWLINE) ? OP_NEWLINE : OP_PUT;
			end
			ACT_BACK:   push_op.kind = OP_BACK;
			ACT_CLEAR:  push_op.kind = OP_CLEAR;
			ACT_SETCUR: push_op.kind = OP_SETCUR;
			ACT_READ:   push_op.kind = OP_READ;
			default:    push_op.kind = OP_NOP;
		endcase
	end

	assign push_addr = in_range ? pos_ext[CUR_W-1:0] : CUR_W'(CELL_COUNT - 1);

endmodule

// File: design/tcw_queue.sv
// Two-entry request queue between the front and the back end.
// No dependencies.
module tcw_queue #(
	parameter int WIDTH = 24
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] din,
	input  logic             pop,
	output logic [WIDTH-1:0] dout,
	output logic             full,
	output logic             empty
);

	localparam logic [1:0] QDEPTH = 2'd2;

	logic [WIDTH-1:0] slot_q [2];
	logic             wr_ptr_q;
	logic             rd_ptr_q;
	logic [1:0]       count_q;

	assign full  = count_q == QDEPTH;
	assign empty = count_q == 2'd0;
	assign dout  = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= din;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

endmodule

// File: design/tcw_back.sv
// Back end: owns the cursor, the screen RAM, the colour register and the result register.
// Depends on tcw_pkg and tcw_ram.
module tcw_back import tcw_pkg::*; #(
	parameter int ROW_COUNT = 25,
	parameter int COL_COUNT = 80,
	localparam int CELL_COUNT = ROW_COUNT * COL_COUNT,
	localparam int CUR_W = $clog2(CELL_COUNT)
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [COLOR_W-1:0]  cfg_color,
	input  logic                q_empty,
	input  op_t                 q_op,
	input  logic [CUR_W-1:0]    q_addr,
	output logic                q_pop,
	output logic                init_busy,
	output logic                out_valid,
	input  logic                out_stall,
	output logic [CURSOR_W-1:0] cursor,
	output logic [CHAR_W-1:0]   cell_char,
	output logic [COLOR_W-1:0]  cell_color
);

	localparam int ROW_W       = $clog2(ROW_COUNT);
	localparam int COL_W       = $clog2(COL_COUNT);
	localparam int SCAN_W      = CUR_W + 1;
	localparam int RECIP_SHIFT = CUR_W + COL_W;
	localparam int RECIP_W     = CUR_W + 1;
	localparam int PROD_W      = CUR_W + RECIP_W;

	localparam logic [CUR_W-1:0]   LAST_CELL      = CUR_W'(CELL_COUNT - 1);
	localparam logic [CUR_W-1:0]   LAST_ROW_START = CUR_W'(CELL_COUNT - COL_COUNT);
	localparam logic [CUR_W-1:0]   COLS_C         = CUR_W'(COL_COUNT);
	localparam logic [RECIP_W-1:0] RECIP          =
		RECIP_W'((2 ** RECIP_SHIFT + COL_COUNT - 1) / COL_COUNT);
	localparam logic [ROW_W-1:0]   LAST_ROW       = ROW_W'(ROW_COUNT - 1);
	localparam logic [COL_W-1:0]   LAST_COL       = COL_W'(COL_COUNT - 1);
	localparam logic [SCAN_W-1:0]  SCAN_FIRST     = SCAN_W'(COL_COUNT);
	localparam logic [SCAN_W-1:0]  SCAN_END       = SCAN_W'(CELL_COUNT);

	localparam logic [2:0] ST_FILL   = 3'd0;
	localparam logic [2:0] ST_IDLE   = 3'd1;
	localparam logic [2:0] ST_SCROLL = 3'd2;
	localparam logic [2:0] ST_READ   = 3'd3;
	localparam logic [2:0] ST_DIV    = 3'd4;
	localparam logic [2:0] ST_COL    = 3'd5;

	logic [2:0]          state_q, state_d;
	logic [CUR_W-1:0]    cur_q, cur_d;
	logic [ROW_W-1:0]    row_q, row_d;
	logic [COL_W-1:0]    col_q, col_d;
	logic [COLOR_W-1:0]  color_q;
	logic                init_q, init_d;
	logic [CUR_W-1:0]    fill_q, fill_d;
	logic [SCAN_W-1:0]   scan_q, scan_d;
	logic                pend_q, pend_d;
	logic [CUR_W-1:0]    pend_addr_q, pend_addr_d;
	logic [PROD_W-1:0]   quot_prod;
	logic                rd_ok_q, rd_ok_d;
	logic                out_valid_q;
	logic [CURSOR_W-1:0] out_cursor_q;
	logic [CHAR_W-1:0]   out_char_q, ld_char;
	logic [COLOR_W-1:0]  out_color_q, ld_color;
	logic                out_free;
	logic                load;
	logic                start_scroll;

	logic                we;
	logic [CUR_W-1:0]    waddr;
	logic [CELL_W-1:0]   wdata;
	logic [CUR_W-1:0]    raddr;
	logic [CELL_W-1:0]   rdata;

	tcw_ram #(
		.WIDTH(CELL_W),
		.DEPTH(CELL_COUNT)
	) u_ram (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.raddr(raddr),
		.rdata(rdata)
	);

	assign out_free  = !out_valid_q || !out_stall;
	assign quot_prod = PROD_W'(cur_q) * PROD_W'(RECIP);

	always_comb begin
		state_d      = state_q;
		cur_d        = cur_q;
		row_d        = row_q;
		col_d        = col_q;
		init_d       = init_q;
		fill_d       = fill_q;
		scan_d       = scan_q;
		pend_d       = 1'b0;
		pend_addr_d  = pend_addr_q;
		rd_ok_d      = rd_ok_q;
		q_pop        = 1'b0;
		we           = 1'b0;
		waddr        = cur_q;
		wdata        = {color_q, q_op.ch};
		raddr        = scan_q[CUR_W-1:0];
		load         = 1'b0;
		ld_char      = '0;
		ld_color     = '0;
		start_scroll = 1'b0;

		unique case (state_q)
			ST_FILL: begin
				we     = 1'b1;
				waddr  = fill_q;
				wdata  = {(init_q ? RESET_ATTR : color_q), CH_SPACE};
				fill_d = fill_q + CUR_W'(1);
				if (fill_q == LAST_CELL) begin
					state_d = ST_IDLE;
					init_d  = 1'b0;
					load    = !init_q;
				end
			end
			ST_IDLE: begin
				if (!q_empty && out_free) begin
					q_pop = 1'b1;
					unique case (q_op.kind)
						OP_PUT: begin
							we    = 1'b1;
							waddr = cur_q;
							wdata = {color_q, q_op.ch};
							if (col_q == LAST_COL) begin
								if (row_q == LAST_ROW) begin
									start_scroll = 1'b1;
								end else begin
									row_d = row_q + ROW_W'(1);
									col_d = '0;
									cur_d = cur_q + CUR_W'(1);
									load  = 1'b1;
								end
							end else begin
								col_d = col_q + COL_W'(1);
								cur_d = cur_q + CUR_W'(1);
								load  = 1'b1;
							end
						end
						OP_NEWLINE: begin
							if (row_q == LAST_ROW) begin
								start_scroll = 1'b1;
							end else begin
								row_d = row_q + ROW_W'(1);
								col_d = '0;
								cur_d = cur_q - CUR_W'(col_q) + COLS_C;
								load  = 1'b1;
							end
						end
						OP_BACK: begin
							if (cur_q != '0) begin
								we    = 1'b1;
								waddr = cur_q - CUR_W'(1);
								wdata = {color_q, CH_SPACE};
								cur_d = cur_q - CUR_W'(1);
								if (col_q == '0) begin
									col_d = LAST_COL;
									row_d = row_q - ROW_W'(1);
								end else begin
									col_d = col_q - COL_W'(1);
								end
							end
							load = 1'b1;
						end
						OP_CLEAR: begin
							cur_d   = '0;
							row_d   = '0;
							col_d   = '0;
							fill_d  = '0;
							state_d = ST_FILL;
						end
						OP_SETCUR: begin
							cur_d   = q_addr;
							state_d = ST_DIV;
						end
						OP_READ: begin
							raddr   = q_addr;
							rd_ok_d = q_op.in_range;
							state_d = ST_READ;
						end
						default: begin
							load = 1'b1;
						end
					endcase
					if (start_scroll) begin
						cur_d   = LAST_ROW_START;
						row_d   = LAST_ROW;
						col_d   = '0;
						scan_d  = SCAN_FIRST;
						state_d = ST_SCROLL;
					end
				end
			end
			ST_SCROLL: begin
				// Each row moves up one cell per cycle; each cell is written from the registered read data.
				if (pend_q) begin
					we    = 1'b1;
					waddr = pend_addr_q;
					wdata = rdata;
				end
				if (scan_q == SCAN_END) begin
					fill_d  = LAST_ROW_START;
					state_d = ST_FILL;
				end else begin
					raddr       = scan_q[CUR_W-1:0];
					pend_d      = 1'b1;
					pend_addr_d = scan_q[CUR_W-1:0] - COLS_C;
					scan_d      = scan_q + SCAN_W'(1);
				end
			end
			ST_READ: begin
				load     = 1'b1;
				ld_char  = rd_ok_q ? rdata[CHAR_W-1:0] : '0;
				ld_color = rd_ok_q ? rdata[CELL_W-1:CHAR_W] : '0;
				state_d  = ST_IDLE;
			end
			ST_DIV: begin
				// The row is the cursor times the rounded-up reciprocal of the row length.
				row_d   = quot_prod[RECIP_SHIFT +: ROW_W];
				state_d = ST_COL;
			end
			ST_COL: begin
				col_d   = COL_W'(cur_q - CUR_W'(row_q) * COLS_C);
				load    = 1'b1;
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_FILL;
			init_q      <= 1'b1;
			fill_q      <= '0;
			cur_q       <= '0;
			row_q       <= '0;
			col_q       <= '0;
			pend_q      <= 1'b0;
			color_q     <= RESET_ATTR;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			init_q  <= init_d;
			fill_q  <= fill_d;
			cur_q   <= cur_d;
			row_q   <= row_d;
			col_q   <= col_d;
			pend_q  <= pend_d;
			if (cfg_we) begin
				color_q <= cfg_color;
			end
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		scan_q      <= scan_d;
		pend_addr_q <= pend_addr_d;
		rd_ok_q     <= rd_ok_d;
		if (load) begin
			out_cursor_q <= CURSOR_W'(cur_d);
			out_char_q   <= ld_char;
			out_color_q  <= ld_color;
		end
	end

	assign init_busy  = init_q;
	assign out_valid  = out_valid_q;
	assign cursor     = out_cursor_q;
	assign cell_char  = out_char_q;
	assign cell_color = out_color_q;

endmodule

// File: design/text_console_writer_top.sv
// Top level of the text console writer: front end, request queue and back end.
// Depends on tcw_pkg, tcw_front, tcw_queue and tcw_back.
//
// Channel  Dir  Handshake            Payload
// cfg      in   cfg_valid/cfg_ready  text_color
// in       in   in_valid/in_stall    action, char_code, position
// out      out  out_valid/out_stall  cursor, cell_char, cell_color
//
// Put-char, newline, backspace and unused codes finish in the idle state, but a put-char at the
// end of the last row or a newline on it starts a scroll; otherwise the result is valid from the
// edge after the back end takes the request. Read-cell passes through a read state for the
// registered RAM read, set-cursor through a row state (reciprocal multiply) and a column state.
// Scroll and clear make one RAM access a cycle. After reset a clearing pass holds in_stall high.
// A stalled result does not block acceptance until the two-entry queue fills.
module text_console_writer_top import tcw_pkg::*; #(
	parameter int ROW_COUNT = 25,
	parameter int COL_COUNT = 80
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [COLOR_W-1:0]  text_color,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [ACTION_W-1:0] action,
	input  logic [CHAR_W-1:0]   char_code,
	input  logic [POS_W-1:0]    position,
	output logic                out_valid,
	input  logic                out_stall,
	output logic [CURSOR_W-1:0] cursor,
	output logic [CHAR_W-1:0]   cell_char,
	output logic [COLOR_W-1:0]  cell_color
);

	localparam int CELL_COUNT = ROW_COUNT * COL_COUNT;
	localparam int CUR_W      = $clog2(CELL_COUNT);
	localparam int OP_W       = $bits(op_t);
	localparam int QW         = OP_W + CUR_W;

	logic             push;
	op_t              push_op;
	logic [CUR_W-1:0] push_addr;
	logic             q_full;
	logic             q_empty;
	logic             q_pop;
	logic [QW-1:0]    q_dout;
	op_t              q_op;
	logic [CUR_W-1:0] q_addr;
	logic             init_busy;

	assign cfg_ready = 1'b1;

	tcw_front #(
		.ROW_COUNT(ROW_COUNT),
		.COL_COUNT(COL_COUNT)
	) u_front (
		.in_valid (in_valid),
		.in_stall (in_stall),
		.action   (action),
		.char_code(char_code),
		.position (position),
		.q_full   (q_full),
		.init_busy(init_busy),
		.push     (push),
		.push_op  (push_op),
		.push_addr(push_addr)
	);

	tcw_queue #(
		.WIDTH(QW)
	) u_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (push),
		.din   ({push_op, push_addr}),
		.pop   (q_pop),
		.dout  (q_dout),
		.full  (q_full),
		.empty (q_empty)
	);

	assign q_op   = op_t'(q_dout[QW-1 -: OP_W]);
	assign q_addr = q_dout[CUR_W-1:0];

	tcw_back #(
		.ROW_COUNT(ROW_COUNT),
		.COL_COUNT(COL_COUNT)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_valid && cfg_ready),
		.cfg_color (text_color),
		.q_empty   (q_empty),
		.q_op      (q_op),
		.q_addr    (q_addr),
		.q_pop     (q_pop),
		.init_busy (init_busy),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cursor    (cursor),
		.cell_char (cell_char),
		.cell_color(cell_color)
	);

endmodule

// File: design/tcw_checker.sv
// Port-level checker for the text console writer, bound to the top level.
// Depends on tcw_pkg and text_console_writer_top_assert.svh.
`include "text_console_writer_top_assert.svh"

module tcw_checker import tcw_pkg::*; #(
	parameter int ROW_COUNT = 25,
	parameter int COL_COUNT = 80
) (
	input logic                clk,
	input logic                arst_n,
	input logic                in_stall,
	input logic                out_valid,
	input logic                out_stall,
	input logic [CURSOR_W-1:0] cursor,
	input logic [CHAR_W-1:0]   cell_char,
	input logic [COLOR_W-1:0]  cell_color
);

	localparam int CELL_COUNT = ROW_COUNT * COL_COUNT;

	`TCW_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid && $stable(cursor) && $stable(cell_char) && $stable(cell_color), "stalled result changed")
	`TCW_ASSERT_NOW(a_cursor_range, clk, arst_n, out_valid, 32'(cursor) < CELL_COUNT, "cursor beyond the screen")
	`TCW_ASSERT_NEXT_ALWAYS(a_reset_pass, clk, !arst_n, in_stall && !out_valid, "no clearing pass after reset")

endmodule

bind text_console_writer_top tcw_checker #(
	.ROW_COUNT(ROW_COUNT),
	.COL_COUNT(COL_COUNT)
) u_tcw_checker (.*);
